// ===== rtl/qsct_pkg.sv =====
// qsct_pkg: shared constants for the quad separating-axis test.
// No dependencies.
package qsct_pkg;
   localparam int COORD_WIDTH_DEF = 24;
   localparam int UNIT_Q14 = 16384;
   localparam int PEN_WIDTH = 24;
   localparam int NORM_WIDTH = 16;
   localparam int SQ_WIDTH = 64;   // radicand width (L2 << 14 fits in 64)
   localparam int SQR_WIDTH = 32;  // root width
   localparam int DIV_WIDTH = 48;  // dividend |a| << 22
endpackage

// ===== rtl/quad_sat_collision_test_core.sv =====
// quad_sat_collision_test_core: separating-axis test of two quads; needs qsct_pkg, qsct_sqrt, qsct_div.
// A slot 0-6 transfer is stored at its accepting edge, one per cycle while idle and no result is pending.
// A slot 7 transfer runs eight axes, each an edge step, halving steps when COORD_WIDTH exceeds 24,
// a root, an x divide and a y divide, eight projections and an overlap check; a zero-length edge
// skips to the overlap check, a separating axis ends the test; then sums, flip and contacts follow.
// One test at a time, input stalled until the result transfer. Sync reset clears store.
module quad_sat_collision_test_core #(
   parameter int COORD_WIDTH = qsct_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_corner_slot,
   input  logic signed [COORD_WIDTH-1:0] req_corner_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner_y,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_collided,
   output logic [qsct_pkg::PEN_WIDTH-1:0] rsp_penetration,
   output logic signed [qsct_pkg::NORM_WIDTH-1:0] rsp_normal_x,
   output logic signed [qsct_pkg::NORM_WIDTH-1:0] rsp_normal_y,
   output logic signed [COORD_WIDTH-1:0] rsp_first_contact_x,
   output logic signed [COORD_WIDTH-1:0] rsp_first_contact_y,
   output logic signed [COORD_WIDTH-1:0] rsp_second_contact_x,
   output logic signed [COORD_WIDTH-1:0] rsp_second_contact_y
);
   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;          // edge component width
   localparam int PW = CW + 18;         // coord * Q1.14 product
   localparam int SW = PW + 1;          // sum of two products
   localparam int NW = qsct_pkg::NORM_WIDTH;

   // states
   localparam logic [3:0] S_IDLE = 4'd0, S_EDGE = 4'd1, S_SHIFT = 4'd2,
      S_SQRT = 4'd3, S_DIVX = 4'd4, S_DIVY = 4'd5, S_PROJ = 4'd6,
      S_OVL = 4'd7, S_SUM = 4'd8, S_DOT = 4'd9, S_CONT = 4'd10,
      S_OUT = 4'd11, S_DIVXW = 4'd12, S_DIVYW = 4'd13;

   logic signed [CW-1:0] cx_ff [8];
   logic signed [CW-1:0] cy_ff [8];
   logic [3:0] st_ff, st_in;
   logic [2:0] ax_ff, ax_in;        // axis index 0..7
   logic [2:0] pi_ff, pi_in;        // projection / contact index
   logic [EW-1:0] ux_ff, ux_in, uy_ff, uy_in;
   logic negx_ff, negx_in, negy_ff, negy_in;
   logic [qsct_pkg::SQR_WIDTH-1:0] len_ff, len_in;
   logic signed [NW-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [SW-1:0] lo_a_ff, lo_a_in, hi_a_ff, hi_a_in;
   logic signed [SW-1:0] lo_b_ff, lo_b_in, hi_b_ff, hi_b_in;
   logic signed [SW-1:0] best_ov_ff, best_ov_in;
   logic have_ff, have_in;
   logic signed [NW-1:0] bnx_ff, bnx_in, bny_ff, bny_in;
   logic signed [CW+2:0] sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic signed [SW+3:0] dotp;
   logic signed [SW-1:0] bp_ff, bp_in, sp_ff, sp_in;
   logic [1:0] bi_ff, bi_in, si_ff, si_in;
   logic bok_ff, bok_in, sok_ff, sok_in;
   logic rv_ff, rv_in, col_ff, col_in;
   logic [qsct_pkg::PEN_WIDTH-1:0] pen_ff, pen_in;

   // serial units
   logic sq_start, sq_done, dv_start, dv_done;
   logic [qsct_pkg::SQ_WIDTH-1:0] sq_rad;
   logic [qsct_pkg::SQR_WIDTH-1:0] sq_root;
   logic [qsct_pkg::DIV_WIDTH-1:0] dv_num, dv_q;
   logic [qsct_pkg::DIV_WIDTH-1:0] qr;
   logic [24:0] ux25, uy25;
   logic [49:0] l2;

   qsct_sqrt u_sqrt (.clock, .reset, .start(sq_start), .radicand(sq_rad),
      .done(sq_done), .root(sq_root));
   qsct_div u_div (.clock, .reset, .start(dv_start), .dividend(dv_num),
      .divisor(len_ff), .done(dv_done), .quotient(dv_q));

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE) || rv_ff;

   // edge endpoints of current axis
   logic [2:0] s_idx, t_idx;
   logic signed [EW-1:0] ax_c, ay_c;
   assign s_idx = ax_ff;
   assign t_idx = {ax_ff[2], ax_ff[1:0] + 2'd1};
   assign ax_c = EW'(cy_ff[t_idx]) - EW'(cy_ff[s_idx]);
   assign ay_c = EW'(cx_ff[s_idx]) - EW'(cx_ff[t_idx]);

   // one projection per cycle, single shared pair of multipliers
   logic signed [SW-1:0] proj;
   logic signed [NW-1:0] mnx, mny;
   logic [2:0] cidx;
   always_comb begin
      mnx = nx_ff; mny = ny_ff; cidx = pi_ff;
      if (st_ff == S_CONT) begin
         mnx = bnx_ff; mny = bny_ff; cidx = {1'b1, pi_ff[1:0]};
      end
   end
   assign proj = SW'(PW'(cx_ff[cidx]) * PW'(mnx)) + SW'(PW'(cy_ff[cidx]) * PW'(mny));

   logic signed [SW-1:0] ov, mx, mn;
   assign mx = (hi_a_ff < hi_b_ff) ? hi_a_ff : hi_b_ff;
   assign mn = (lo_a_ff > lo_b_ff) ? lo_a_ff : lo_b_ff;
   assign ov = mx - mn;
   assign dotp = (SW+4)'(sdx_ff) * (SW+4)'(bnx_ff) + (SW+4)'(sdy_ff) * (SW+4)'(bny_ff);

   // magnitudes are below 2^24 once halving is done
   assign ux25 = 25'(ux_ff);
   assign uy25 = 25'(uy_ff);
   assign l2 = 50'(ux25) * 50'(ux25) + 50'(uy25) * 50'(uy25);
   assign sq_rad = {l2[49:0], 14'd0};
   assign qr = (dv_q + 48'd1) >> 1;

   logic [NW-1:0] qclamp;
   assign qclamp = (qr > 48'(qsct_pkg::UNIT_Q14)) ? NW'(qsct_pkg::UNIT_Q14) : NW'(qr);

   always_comb begin
      st_in = st_ff; ax_in = ax_ff; pi_in = pi_ff;
      ux_in = ux_ff; uy_in = uy_ff; negx_in = negx_ff; negy_in = negy_ff;
      len_in = len_ff; nx_in = nx_ff; ny_in = ny_ff;
      lo_a_in = lo_a_ff; hi_a_in = hi_a_ff; lo_b_in = lo_b_ff; hi_b_in = hi_b_ff;
      best_ov_in = best_ov_ff; have_in = have_ff; bnx_in = bnx_ff; bny_in = bny_ff;
      sdx_in = sdx_ff; sdy_in = sdy_ff; bp_in = bp_ff; sp_in = sp_ff;
      bi_in = bi_ff; si_in = si_ff; bok_in = bok_ff; sok_in = sok_ff;
      rv_in = rv_ff; col_in = col_ff; pen_in = pen_ff;
      sq_start = 1'b0; dv_start = 1'b0; dv_num = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (accept && req_corner_slot == 3'd7) begin
               st_in = S_EDGE; ax_in = '0; have_in = 1'b0;
               sdx_in = '0; sdy_in = '0;
            end
         end
         S_EDGE: begin
            negx_in = ax_c[EW-1]; negy_in = ay_c[EW-1];
            ux_in = ax_c[EW-1] ? EW'(-ax_c) : EW'(ax_c);
            uy_in = ay_c[EW-1] ? EW'(-ay_c) : EW'(ay_c);
            st_in = (ax_c == '0 && ay_c == '0) ? S_OVL : S_SHIFT;
            if (ax_c == '0 && ay_c == '0) pi_in = 3'd7; // marks skipped axis
            else pi_in = 3'd0;
         end
         S_SHIFT: begin
            // one halving per cycle until both below 2^24
            if ((ux_ff >> 24) != '0 || (uy_ff >> 24) != '0) begin
               ux_in = ux_ff >> 1; uy_in = uy_ff >> 1;
            end else begin
               sq_start = 1'b1; st_in = S_SQRT;
            end
         end
         S_SQRT: if (sq_done) begin
            len_in = sq_root; st_in = S_DIVX;
         end
         S_DIVX: begin
            dv_start = 1'b1;
            dv_num = 48'(ux25) << 22;
            st_in = S_DIVXW;
         end
         S_DIVXW: if (dv_done) begin
            nx_in = negx_ff ? NW'(-qclamp) : NW'(qclamp); st_in = S_DIVY;
         end
         S_DIVY: begin
            dv_start = 1'b1; dv_num = 48'(uy25) << 22; st_in = S_DIVYW;
         end
         S_DIVYW: if (dv_done) begin
            ny_in = negy_ff ? NW'(-qclamp) : NW'(qclamp); st_in = S_PROJ;
            pi_in = 3'd0;
         end
         S_PROJ: begin
            if (pi_ff[1:0] == 2'd0) begin
               if (!pi_ff[2]) begin lo_a_in = proj; hi_a_in = proj; end
               else begin lo_b_in = proj; hi_b_in = proj; end
            end else if (!pi_ff[2]) begin
               if (proj < lo_a_ff) lo_a_in = proj;
               if (proj > hi_a_ff) hi_a_in = proj;
            end else begin
               if (proj < lo_b_ff) lo_b_in = proj;
               if (proj > hi_b_ff) hi_b_in = proj;
            end
            pi_in = pi_ff + 3'd1;
            if (pi_ff == 3'd7) begin st_in = S_OVL; pi_in = 3'd0; end
         end
         S_OVL: begin
            // pi_ff==7 here only when axis was skipped
            if (pi_ff == 3'd7) begin
               pi_in = 3'd0;
               ax_in = ax_ff + 3'd1;
               st_in = (ax_ff == 3'd7) ? S_SUM : S_EDGE;
            end else if (ov <= 0) begin
               col_in = 1'b0; pen_in = '0; bnx_in = '0; bny_in = '0;
               st_in = S_OUT; bi_in = '0; si_in = '0; bok_in = 1'b0;
            end else begin
               if (!have_ff || ov < best_ov_ff) begin
                  have_in = 1'b1; best_ov_in = ov; bnx_in = nx_ff; bny_in = ny_ff;
               end
               ax_in = ax_ff + 3'd1;
               st_in = (ax_ff == 3'd7) ? S_SUM : S_EDGE;
            end
         end
         S_SUM: begin
            sdx_in = sdx_ff + (CW+3)'(cx_ff[{1'b0, pi_ff[1:0]}])
               - (CW+3)'(cx_ff[{1'b1, pi_ff[1:0]}]);
            sdy_in = sdy_ff + (CW+3)'(cy_ff[{1'b0, pi_ff[1:0]}])
               - (CW+3)'(cy_ff[{1'b1, pi_ff[1:0]}]);
            pi_in = pi_ff + 3'd1;
            if (pi_ff == 3'd3) begin
               st_in = S_DOT; pi_in = 3'd0;
               if (!have_ff) begin bnx_in = '0; bny_in = '0; end
            end
         end
         S_DOT: begin
            if (dotp < 0) begin bnx_in = -bnx_ff; bny_in = -bny_ff; end
            bok_in = 1'b0; sok_in = 1'b0; bi_in = '0; si_in = '0;
            col_in = 1'b1;
            if (have_ff) begin
               pen_in = ((best_ov_ff + SW'(8192)) >>> 14) > SW'(24'hFFFFFF) ?
                  24'hFFFFFF : 24'((best_ov_ff + SW'(8192)) >>> 14);
            end else pen_in = 24'hFFFFFF;
            st_in = S_CONT;
         end
         S_CONT: begin
            if (!bok_ff || proj > bp_ff) begin
               if (bok_ff) begin sp_in = bp_ff; si_in = bi_ff; sok_in = 1'b1; end
               bp_in = proj; bi_in = pi_ff[1:0]; bok_in = 1'b1;
            end else if (!sok_ff || proj > sp_ff) begin
               sp_in = proj; si_in = pi_ff[1:0]; sok_in = 1'b1;
            end
            pi_in = pi_ff + 3'd1;
            if (pi_ff == 3'd3) st_in = S_OUT;
         end
         S_OUT: begin
            rv_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            cx_ff[i] <= '0; cy_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in; rv_ff <= rv_in;
         if (accept) begin
            cx_ff[req_corner_slot] <= req_corner_x;
            cy_ff[req_corner_slot] <= req_corner_y;
         end
      end
      ax_ff <= ax_in; pi_ff <= pi_in; ux_ff <= ux_in; uy_ff <= uy_in;
      negx_ff <= negx_in; negy_ff <= negy_in; len_ff <= len_in;
      nx_ff <= nx_in; ny_ff <= ny_in; lo_a_ff <= lo_a_in; hi_a_ff <= hi_a_in;
      lo_b_ff <= lo_b_in; hi_b_ff <= hi_b_in; best_ov_ff <= best_ov_in;
      have_ff <= have_in; bnx_ff <= bnx_in; bny_ff <= bny_in;
      sdx_ff <= sdx_in; sdy_ff <= sdy_in; bp_ff <= bp_in; sp_ff <= sp_in;
      bi_ff <= bi_in; si_ff <= si_in; bok_ff <= bok_in; sok_ff <= sok_in;
      col_ff <= col_in; pen_ff <= pen_in;
   end

   // no-collision result zeroes the contacts
   assign rsp_valid = rv_ff;
   assign rsp_collided = col_ff;
   assign rsp_penetration = pen_ff;
   assign rsp_normal_x = bnx_ff;
   assign rsp_normal_y = bny_ff;
   assign rsp_first_contact_x = col_ff ? cx_ff[{1'b1, bi_ff}] : '0;
   assign rsp_first_contact_y = col_ff ? cy_ff[{1'b1, bi_ff}] : '0;
   assign rsp_second_contact_x = col_ff ? cx_ff[{1'b1, si_ff}] : '0;
   assign rsp_second_contact_y = col_ff ? cy_ff[{1'b1, si_ff}] : '0;
endmodule

// ===== rtl/qsct_sqrt.sv =====
// qsct_sqrt: bit-serial integer square root, one result bit per cycle.
// Depends on qsct_pkg.
module qsct_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [qsct_pkg::SQ_WIDTH-1:0] radicand,
   output logic done,
   output logic [qsct_pkg::SQR_WIDTH-1:0] root
);
   localparam int W = qsct_pkg::SQ_WIDTH;
   localparam int RW = qsct_pkg::SQR_WIDTH;
   logic [W-1:0] v_ff, v_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW-1:0] r_ff, r_in;
   logic [5:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;
   logic [RW+1:0] trial, remsh;

   always_comb begin
      v_in = v_ff; rem_in = rem_ff; r_in = r_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      remsh = {rem_ff[RW-1:0], v_ff[W-1:W-2]};
      trial = {r_ff, 2'b01};
      if (start) begin
         v_in = radicand; rem_in = '0; r_in = '0; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         v_in = {v_ff[W-3:0], 2'b00};
         if (remsh >= trial) begin
            rem_in = remsh - trial; r_in = {r_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = remsh; r_in = {r_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(RW-1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      v_ff <= v_in; rem_ff <= rem_in; r_ff <= r_in; cnt_ff <= cnt_in;
   end
   assign done = done_ff;
   assign root = r_ff;
endmodule

// ===== rtl/qsct_div.sv =====
// qsct_div: restoring divider, one quotient bit per cycle.
// Depends on qsct_pkg.
module qsct_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [qsct_pkg::DIV_WIDTH-1:0] dividend,
   input  logic [qsct_pkg::SQR_WIDTH-1:0] divisor,
   output logic done,
   output logic [qsct_pkg::DIV_WIDTH-1:0] quotient
);
   localparam int W = qsct_pkg::DIV_WIDTH;
   localparam int DW = qsct_pkg::SQR_WIDTH;
   logic [W-1:0] q_ff, q_in;
   logic [DW:0] rem_ff, rem_in, sh;
   logic [DW-1:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      sh = {rem_ff[DW-1:0], q_ff[W-1]};
      if (start) begin
         q_in = dividend; rem_in = '0; d_in = divisor; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            rem_in = sh - {1'b0, d_ff}; q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = sh; q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(W-1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; d_ff <= d_in; cnt_ff <= cnt_in;
   end
   assign done = done_ff;
   assign quotient = q_ff;
endmodule
